// File: hw/rtl/tws_pkg.sv
`timescale 1ns / 1ps
// Package for the three-wire serial register master.
// Holds request codes, register indexes, phase enum and the structs shared by
// tws_engine and the top level. No dependencies.
package tws_pkg;

  localparam int unsigned BitsPerByte = 8;
  localparam int unsigned BitCntW     = $clog2(BitsPerByte);
  localparam int unsigned HalfW       = 8;
  localparam int unsigned HoldW       = 10;
  localparam int unsigned TickW       = 10;
  localparam int unsigned CfgDataW    = 10;

  // request codes
  localparam logic [1:0] ReqTick  = 2'd0;
  localparam logic [1:0] ReqRead  = 2'd1;
  localparam logic [1:0] ReqWrite = 2'd2;

  // configuration register indexes
  localparam logic CfgIdxHalfPeriod = 1'b0;
  localparam logic CfgIdxEndHold    = 1'b1;

  localparam logic [HalfW-1:0] HalfPeriodRst = HalfW'(2);
  localparam logic [HoldW-1:0] EndHoldRst    = HoldW'(20);

  typedef enum logic [1:0] {
    PhIdle = 2'd0,
    PhAddr = 2'd1,
    PhData = 2'd2,
    PhHold = 2'd3
  } phase_e;

  typedef struct packed {
    logic [HalfW-1:0] half_period;
    logic [HoldW-1:0] end_hold;
  } tws_cfg_t;

  typedef struct packed {
    logic              cs_n;
    logic              sclk;
    logic              sdio_out;
    logic              sdio_drive;
    logic signed [7:0] read_value;
    logic              done;
    logic              busy;
  } tws_result_t;

endpackage

// File: hw/rtl/tws_engine.sv
`timescale 1ns / 1ps
// Bit engine of the three-wire serial master: phase, shift and tick state.
// Advances one tick per step and presents the resulting pin levels. Uses tws_pkg.
module tws_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          req_type_i,
  input  logic [7:0]          reg_addr_i,
  input  logic [7:0]          write_data_i,
  input  logic                sdio_in_i,
  input  tws_pkg::tws_cfg_t   cfg_i,
  output tws_pkg::tws_result_t res_o
);
  import tws_pkg::*;

  phase_e             phase_q, phase_d;
  logic [BitCntW-1:0] bit_q, bit_d;
  logic [7:0]         tx_q, tx_d;
  logic [7:0]         rx_q, rx_d;
  logic [TickW-1:0]   tick_q, tick_d;
  logic               wr_q, wr_d;
  logic               sclk_q, sclk_d;
  logic [7:0]         last_q, last_d;
  logic               done;
  logic [TickW-1:0]   half;
  logic [TickW-1:0]   tick_inc;
  logic               drive;

  // zero half period counts as one tick
  assign half     = (cfg_i.half_period == '0) ? TickW'(1) : TickW'(cfg_i.half_period);
  assign tick_inc = tick_q + TickW'(1);

  // next state for one tick
  always_comb begin
    phase_d = phase_q;
    bit_d   = bit_q;
    tx_d    = tx_q;
    rx_d    = rx_q;
    tick_d  = tick_q;
    wr_d    = wr_q;
    sclk_d  = sclk_q;
    last_d  = last_q;
    done    = 1'b0;
    unique case (phase_q)
      PhIdle: begin
        if (req_type_i == ReqRead || req_type_i == ReqWrite) begin
          phase_d = PhAddr;
          wr_d    = (req_type_i == ReqWrite);
          tx_d    = reg_addr_i;
          rx_d    = (req_type_i == ReqWrite) ? write_data_i : 8'h00;
          bit_d   = '0;
          sclk_d  = 1'b0;
          tick_d  = TickW'(1);
        end
      end
      PhHold: begin
        tick_d = tick_inc;
        if (tick_inc >= cfg_i.end_hold) begin
          phase_d = PhIdle;
          done    = 1'b1;
        end
      end
      PhAddr, PhData: begin
        if (tick_q < half) begin
          tick_d = tick_inc;
        end else begin
          tick_d = TickW'(1);
          if (!sclk_q) begin
            // rising edge: sample on a read
            sclk_d = 1'b1;
            if (phase_q == PhData && !wr_q) rx_d = {rx_q[6:0], sdio_in_i};
          end else if (bit_q != BitCntW'(BitsPerByte - 1)) begin
            // falling edge inside a byte
            tx_d   = {tx_q[6:0], 1'b0};
            bit_d  = bit_q + BitCntW'(1);
            sclk_d = 1'b0;
          end else begin
            // end of a byte
            tx_d  = {tx_q[6:0], 1'b0};
            bit_d = '0;
            if (phase_q == PhAddr) begin
              phase_d = PhData;
              tx_d    = wr_q ? rx_q : 8'h00;
              rx_d    = 8'h00;
              sclk_d  = 1'b0;
            end else begin
              if (!wr_q) last_d = rx_q;
              if (cfg_i.end_hold == '0) begin
                phase_d = PhIdle;
                done    = 1'b1;
              end else begin
                phase_d = PhHold;
                tick_d  = '0;
              end
            end
          end
        end
      end
      default: phase_d = PhIdle;
    endcase
  end

  // pin levels after this tick
  always_comb begin
    drive              = (phase_d == PhAddr) || (phase_d == PhData && wr_d);
    res_o.cs_n         = (phase_d == PhIdle);
    res_o.sclk         = sclk_d;
    res_o.sdio_out     = drive & tx_d[7];
    res_o.sdio_drive   = drive;
    res_o.read_value   = $signed(last_d);
    res_o.done         = done;
    res_o.busy         = (phase_d != PhIdle);
  end

  // advance state once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      bit_q   <= '0;
      tx_q    <= '0;
      rx_q    <= '0;
      tick_q  <= '0;
      wr_q    <= 1'b0;
      sclk_q  <= 1'b1;
      last_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      bit_q   <= bit_d;
      tx_q    <= tx_d;
      rx_q    <= rx_d;
      tick_q  <= tick_d;
      wr_q    <= wr_d;
      sclk_q  <= sclk_d;
      last_q  <= last_d;
    end
  end

`ifndef SYNTH
  a_done_deselects : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.done |-> res_o.cs_n)
    else $error("done reported with chip select still low");
  a_drive_selected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.sdio_drive |-> !res_o.cs_n)
    else $error("data line driven while deselected");
  a_idle_clock_high : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhIdle |-> sclk_q)
    else $error("serial clock low while idle");
  a_hold_no_drive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhHold |-> sclk_q && bit_q == '0)
    else $error("hold phase entered mid byte");
  a_stall_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(phase_q) && $stable(tick_q))
    else $error("state moved without a request");
`endif

endmodule

// File: hw/rtl/three_wire_serial_register_master_top.sv
`timescale 1ns / 1ps
// Top level of the three-wire serial register master: configuration
// registers, tws_engine and the result register. Uses tws_pkg.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   request  | in_valid_i / in_ready_o| req_type_i reg_addr_i write_data_i sdio_in_i
//   result   | out_valid_o/out_ready_i| chip_select_n_o serial_clock_o sdio_out_o
//            |                        | sdio_drive_o read_value_o done_res_o busy_res_o
//   config   | cfg_we_i               | cfg_idx_i cfg_wdata_i
//
// One request (one tick) is taken per clock cycle; its result appears in the
// result register on the next cycle. The tick logic sits between the engine
// state registers and the result register. A request is taken while the result
// register is empty or being drained, so a full result register with
// out_ready_i low stalls the request side. Reset idles the engine with the
// serial clock high, half period 2 and hold 20.
module three_wire_serial_register_master_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          req_type_i,
  input  logic [7:0]          reg_addr_i,
  input  logic [7:0]          write_data_i,
  input  logic                sdio_in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                chip_select_n_o,
  output logic                serial_clock_o,
  output logic                sdio_out_o,
  output logic                sdio_drive_o,
  output logic signed [7:0]   read_value_o,
  output logic                done_res_o,
  output logic                busy_res_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [tws_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import tws_pkg::*;

  tws_cfg_t    cfg_q;
  tws_result_t res;
  tws_result_t res_q;
  logic        out_valid_q, out_valid_d;
  logic        step;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= HalfPeriodRst;
      cfg_q.end_hold    <= EndHoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxHalfPeriod: cfg_q.half_period <= cfg_wdata_i[HalfW-1:0];
        CfgIdxEndHold:    cfg_q.end_hold    <= cfg_wdata_i[HoldW-1:0];
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  tws_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .req_type_i   (req_type_i),
    .reg_addr_i   (reg_addr_i),
    .write_data_i (write_data_i),
    .sdio_in_i    (sdio_in_i),
    .cfg_i        (cfg_q),
    .res_o        (res)
  );

  // result valid: set on a request, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // hold the result payload
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chip_select_n_o = res_q.cs_n;
  assign serial_clock_o  = res_q.sclk;
  assign sdio_out_o      = res_q.sdio_out;
  assign sdio_drive_o    = res_q.sdio_drive;
  assign read_value_o    = res_q.read_value;
  assign done_res_o      = res_q.done;
  assign busy_res_o      = res_q.busy;

endmodule
